/* rtl/aes_pkg.sv */
// Package for the AES-128 CBC decryption block: types, constants, GF(2^8) and S-box functions.
// Used by the interfaces, the key expander and the top level.
package aes_pkg;

    localparam int NUM_ROUNDS     = 10;
    localparam int NUM_ROUND_KEYS = 11;
    localparam int KEY_DEPTH      = 22;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_OUT  = 2'd2
    } t_dec_state;

    typedef enum logic [1:0] {
        KS_IDLE = 2'd0,
        KS_RUN  = 2'd1
    } t_ks_state;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // InvMixColumns over a 128-bit state, byte 0 in bits 127:120
    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            o[127 - 32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
            o[119 - 32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
            o[111 - 32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
            o[103 - 32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
        end
        inv_mix = o;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8*(4*c + r) -: 8] = INV_SBOX[s[127 - 8*(4*((c - r + 4) % 4) + r) -: 8]];
            end
        end
        inv_shift_sub = o;
    endfunction

endpackage

/* rtl/aes_if.sv */
// Valid/ready channel interfaces for cipher items, plain items and configuration writes.
// Depends on aes_pkg.
interface aes_cipher_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        block_last_in;
    modport source (output valid, cipher_high, cipher_low, block_last_in, input ready);
    modport sink   (input valid, cipher_high, cipher_low, block_last_in, output ready);
endinterface

interface aes_plain_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        block_last_out;
    modport source (output valid, plain_high, plain_low, block_last_out, input ready);
    modport sink   (input valid, plain_high, plain_low, block_last_out, output ready);
endinterface

interface aes_cfg_if
    import aes_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/aes_keyexp.sv */
// Round-key expander: derives each full round key from the one before, writes the key store.
// Depends on aes_pkg.
module aes_keyexp
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [3:0]   i_rd_round,
    output logic [127:0] o_rd_key,
    output logic         o_busy
);

    t_ks_state     r_state, n_state;
    logic [127:0]  r_w, n_w;
    logic [3:0]    r_round, n_round;
    logic [7:0]    r_rcon, n_rcon;
    logic [127:0]  r_store [NUM_ROUND_KEYS];
    logic [127:0]  r_rd;
    logic          wr_en;
    logic [3:0]    wr_addr;
    logic [127:0]  wr_data;
    logic [31:0]   t, w0, w1, w2, w3;
    logic [127:0]  nxt;

    always_comb begin
        t  = {SBOX[r_w[23:16]] ^ r_rcon, SBOX[r_w[15:8]], SBOX[r_w[7:0]], SBOX[r_w[31:24]]};
        w0 = r_w[127:96] ^ t;
        w1 = r_w[95:64] ^ w0;
        w2 = r_w[63:32] ^ w1;
        w3 = r_w[31:0] ^ w2;
        nxt = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_RUN;
            r_round <= 4'd0;
            r_rcon  <= 8'h01;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_rcon  <= n_rcon;
            r_w     <= n_w;
        end
    end

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_round = r_round;
        n_rcon  = r_rcon;
        wr_en   = 1'b0;
        wr_addr = r_round;
        wr_data = r_w;
        unique case (r_state)
            KS_IDLE: begin
                if (i_start) begin
                    n_state = KS_RUN;
                    n_w     = i_key;
                    n_round = 4'd0;
                    n_rcon  = 8'h01;
                end
            end
            KS_RUN: begin
                wr_en   = 1'b1;
                wr_data = (r_round == 4'd0 || r_round == 4'(NUM_ROUNDS)) ? r_w : inv_mix(r_w);
                n_w     = nxt;
                n_rcon  = xt(r_rcon);
                n_round = r_round + 4'd1;
                if (r_round == 4'(NUM_ROUNDS)) n_state = KS_IDLE;
            end
            default: n_state = KS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_store[wr_addr] <= wr_data;
        r_rd <= r_store[i_rd_round];
    end

    assign o_rd_key = r_rd;
    assign o_busy   = (r_state == KS_RUN);

endmodule

/* rtl/aes128_cbc_decrypt.sv */
// Top level of the AES-128 CBC decryption block: round sequencer, chaining value, config regs.
// Depends on aes_pkg, aes_if and aes_keyexp.
//
//  channel   dir   handshake     payload
//  s_in      in    valid/ready   cipher_high, cipher_low, block_last_in
//  m_out     out   valid/ready   plain_high, plain_low, block_last_out
//  s_cfg     in    valid/ready   index, data
//
// Each item runs all its rounds in the shared round unit, then waits in the output register;
// the round-key memory read (one registered port) paces the rounds. After reset or a key write
// the expander runs, during which no item and no write is taken. The output register
// holds a result until taken; the next item is accepted once it is gone.
module aes128_cbc_decrypt
    import aes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    aes_cipher_if.sink  s_in,
    aes_plain_if.source m_out,
    aes_cfg_if.sink     s_cfg
);

    t_dec_state    r_state, n_state;
    logic [127:0]  r_key, r_chain, r_s, n_s, r_ct, r_out;
    logic          r_last, r_olast, r_kstart;
    logic [3:0]    r_rnd, n_rnd;
    logic [127:0]  rk;
    logic          ks_busy;
    logic          in_acc, cfg_acc;

    aes_keyexp u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kstart),
        .i_key      (r_key),
        .i_rd_round (n_rnd),
        .o_rd_key   (rk),
        .o_busy     (ks_busy)
    );

    assign s_cfg.ready = (r_state == ST_IDLE) && !ks_busy && !r_kstart;
    assign cfg_acc     = s_cfg.valid && s_cfg.ready;
    assign s_in.ready  = (r_state == ST_IDLE) && !ks_busy && !r_kstart && !s_cfg.valid;
    assign in_acc      = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_key    <= '0;
            r_chain  <= '0;
            r_kstart <= 1'b0;
            r_rnd    <= 4'(NUM_ROUNDS);
        end else begin
            r_state  <= n_state;
            r_rnd    <= n_rnd;
            r_kstart <= 1'b0;
            if (cfg_acc) begin
                unique case (t_reg_idx'(s_cfg.index))
                    REG_KEY_HIGH: begin r_key[127:64] <= s_cfg.data; r_kstart <= 1'b1; end
                    REG_KEY_LOW:  begin r_key[63:0]   <= s_cfg.data; r_kstart <= 1'b1; end
                    REG_IV_HIGH:  r_chain[127:64] <= s_cfg.data;
                    REG_IV_LOW:   r_chain[63:0]   <= s_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == ST_RUN && r_rnd == 4'd0) r_chain <= r_ct;
        end
        r_s <= n_s;
        if (in_acc) begin
            r_ct   <= {s_in.cipher_high, s_in.cipher_low};
            r_last <= s_in.block_last_in;
        end
        if (r_state == ST_RUN && r_rnd == 4'd0) begin
            r_out   <= inv_shift_sub(r_s) ^ rk ^ r_chain;
            r_olast <= r_last;
        end
    end

    // r_rnd names the key on rk; the key memory registers its read, so a key arrives in the cycle after its address
    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_s     = r_s;
        unique case (r_state)
            ST_IDLE: begin
                n_rnd = 4'(NUM_ROUNDS);
                if (in_acc) begin
                    n_state = ST_RUN;
                    n_s     = {s_in.cipher_high, s_in.cipher_low};
                end
            end
            ST_RUN: begin
                // first cycle: key for round ten, initial addition
                if (r_rnd == 4'(NUM_ROUNDS)) n_s = r_s ^ rk;
                else if (r_rnd != 4'd0) n_s = inv_mix(inv_shift_sub(r_s)) ^ rk;
                if (r_rnd == 4'd0) n_state = ST_OUT;
                else n_rnd = r_rnd - 4'd1;
            end
            ST_OUT: begin
                n_rnd = 4'(NUM_ROUNDS);
                if (m_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_out.valid          = (r_state == ST_OUT);
    assign m_out.plain_high     = r_out[127:64];
    assign m_out.plain_low      = r_out[63:0];
    assign m_out.block_last_out = r_olast;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready) else $error("input taken while result pending");
    a_no_ks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !ks_busy) else $error("rounds run during key expansion");
    a_out_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_out.valid) |-> $past(r_state == ST_RUN)) else $error("result without rounds");

endmodule
